>>> sv/linear_chirp_sample_generator_defines.svh
// ----------------------------------------------------------------------------
// Linear chirp sample generator - assertion macros
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH
`define LINEAR_CHIRP_SAMPLE_GENERATOR_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define LCSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lcsg_pkg.sv
// ----------------------------------------------------------------------------
// lcsg_pkg
// Widths, register indexes and the quarter-wave sine table of the chirp
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int COUNT_BITS      = 20;
  localparam int TABLE_ADDR_BITS = 10;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam int QTR       = 1 << (TABLE_ADDR_BITS - 2);
  localparam int MAG_BITS  = SAMPLE_BITS - 1;
  localparam longint unsigned AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned QTR_HALF = 64'd1 << (TABLE_ADDR_BITS - 3);
  localparam logic [COUNT_BITS-1:0] SWEEP_RESET = COUNT_BITS'(1024);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_STEP   = 2'd0,
    REG_CHIRP_STEP   = 2'd1,
    REG_SWEEP_LENGTH = 2'd2,
    REG_PAD_LENGTH   = 2'd3
  } cfg_reg_t;

  typedef logic [MAG_BITS-1:0] quarter_tab_t [0:QTR];

  // Quarter-wave sine, Taylor series in Q30, rounded half up to AMP scale.
  // Each term divides the previous one by (2n)(2n+1), n = 1..8.
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t    tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k <= QTR; k++) begin
      x    = (PI_HALF_Q30 * longint'(k) + QTR_HALF) >> (TABLE_ADDR_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      v = (longint'(sum) * AMP + (64'd1 << 29)) >> 30;
      if (v > AMP) begin
        v = AMP;
      end
      tab[k] = MAG_BITS'(v);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_TAB = build_quarter();

  // Full-wave sine from the quarter table: mirror in odd quadrants,
  // negate in the lower half-turn.
  function automatic logic signed [SAMPLE_BITS-1:0] sine_at(
    input logic [TABLE_ADDR_BITS-1:0] addr
  );
    logic [1:0]                    quad;
    logic [TABLE_ADDR_BITS-3:0]    r;
    logic [MAG_BITS-1:0]           m;
    logic signed [SAMPLE_BITS-1:0] mag;
    quad = addr[TABLE_ADDR_BITS-1 -: 2];
    r    = addr[TABLE_ADDR_BITS-3:0];
    if (quad[0]) begin
      m = QUARTER_TAB[QTR - int'(r)];
    end else begin
      m = QUARTER_TAB[int'(r)];
    end
    mag = signed'({1'b0, m});
    return quad[1] ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

>>> sv/linear_chirp_sample_generator.sv
// ----------------------------------------------------------------------------
// linear_chirp_sample_generator
// Linear FM pulse source: a two-stage DDS (step and phase accumulators)
// driving a quarter-wave sine table, followed by zero padding per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_restart): every accepted
//   transaction requests one complex sample. in_restart high starts a new
//   frame at sample zero with that very transaction.
//   Result channel (out_valid / out_stall / out_i_sample, out_q_sample,
//   out_in_pad, out_last): one transaction per accepted input, in order.
//   out_last flags the final sample of a frame (chirp plus padding).
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   always ready; write only while no sample is in flight.
//   Timing: the accepting edge loads the address register, and the output
//   register loads from it when it is empty or being taken. Throughput:
//   one sample per clock while out_stall is low; step and phase accumulators
//   and frame counter advance together in the acceptance cycle, and the
//   table lookup sits between the address register and the output register.
//   Stall: a stalled output holds; the address stage still fills, and
//   in_stall rises only once both stages are occupied.
//   Reset (synchronous, rst_n low): empty the pipeline, clear the
//   accumulators and counter, set sweep_length to 1024, other registers 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_chirp_sample_generator_defines.svh"

module linear_chirp_sample_generator (
  input  wire  logic                                   clk,
  input  wire  logic                                   rst_n,
  // input channel
  input  wire  logic                                   in_valid,
  output logic                                         in_stall,
  input  wire  logic                                   in_restart,
  // result channel
  output logic                                         out_valid,
  input  wire  logic                                   out_stall,
  output logic signed [lcsg_pkg::SAMPLE_BITS-1:0]      out_i_sample,
  output logic signed [lcsg_pkg::SAMPLE_BITS-1:0]      out_q_sample,
  output logic                                         out_in_pad,
  output logic                                         out_last,
  // configuration channel
  input  wire  logic                                   cfg_valid,
  output logic                                         cfg_ready,
  input  wire  logic [lcsg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  logic [lcsg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int PB = lcsg_pkg::PHASE_BITS;
  localparam int CB = lcsg_pkg::COUNT_BITS;
  localparam int AB = lcsg_pkg::TABLE_ADDR_BITS;
  localparam int SB = lcsg_pkg::SAMPLE_BITS;

  // Configuration registers
  logic [PB-1:0] start_step_r;
  logic [PB-1:0] chirp_step_r;
  logic [CB-1:0] sweep_length_r;
  logic [CB-1:0] pad_length_r;

  // DDS and frame state
  logic [PB-1:0] phase_acc_r, phase_acc_nxt;
  logic [PB-1:0] step_acc_r,  step_acc_nxt;
  logic [CB:0]   sample_count_r, sample_count_nxt;

  // Address stage
  logic          s1_valid_r;
  logic [AB-1:0] s1_addr_r;
  logic          s1_pad_r;
  logic          s1_last_r;

  // Output stage
  logic                 out_valid_r;
  logic signed [SB-1:0] out_i_r;
  logic signed [SB-1:0] out_q_r;
  logic                 out_pad_r;
  logic                 out_last_r;

  // Per-sample combinational values
  logic          in_accept;
  logic          out_load;
  logic [PB-1:0] ph_cur;
  logic [PB-1:0] st_cur;
  logic [CB:0]   n_cur;
  logic [CB-1:0] sweep_eff;
  logic [CB:0]   total;
  logic          chirp_now;
  logic          last_now;

  // --------------------------------------------------------------------------
  // Handshake: the output register loads when empty or being taken; the
  // address stage loads when empty or when it can move on.
  // --------------------------------------------------------------------------
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration writes. Steps are sign-extended or cut to phase width.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r   <= '0;
      chirp_step_r   <= '0;
      sweep_length_r <= lcsg_pkg::SWEEP_RESET;
      pad_length_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (lcsg_pkg::cfg_reg_t'(cfg_index))
        lcsg_pkg::REG_START_STEP:   start_step_r   <= PB'(signed'(cfg_data));
        lcsg_pkg::REG_CHIRP_STEP:   chirp_step_r   <= PB'(signed'(cfg_data));
        lcsg_pkg::REG_SWEEP_LENGTH: sweep_length_r <= cfg_data[CB-1:0];
        lcsg_pkg::REG_PAD_LENGTH:   pad_length_r   <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame and DDS update for one sample.
  // A restart rewinds the frame before this sample is produced. Chirp
  // samples advance phase by the step and the step by chirp_step; padding
  // holds both. The final sample of the frame (also when a shortened
  // frame leaves the count past its end) rewinds to the frame start.
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_restart) begin
      ph_cur = '0;
      st_cur = start_step_r;
      n_cur  = '0;
    end else begin
      ph_cur = phase_acc_r;
      st_cur = step_acc_r;
      n_cur  = sample_count_r;
    end

    // Treat a zero sweep length as one.
    sweep_eff = (sweep_length_r == '0) ? CB'(1) : sweep_length_r;
    total     = {1'b0, sweep_eff} + {1'b0, pad_length_r};
    chirp_now = n_cur < {1'b0, sweep_eff};
    last_now  = n_cur >= (total - (CB+1)'(1));

    phase_acc_nxt = ph_cur;
    step_acc_nxt  = st_cur;
    if (chirp_now) begin
      phase_acc_nxt = ph_cur + st_cur;
      step_acc_nxt  = st_cur + chirp_step_r;
    end

    if (last_now) begin
      phase_acc_nxt    = '0;
      step_acc_nxt     = start_step_r;
      sample_count_nxt = '0;
    end else begin
      sample_count_nxt = n_cur + (CB+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      step_acc_r     <= '0;
      sample_count_r <= '0;
    end else if (in_accept) begin
      phase_acc_r    <= phase_acc_nxt;
      step_acc_r     <= step_acc_nxt;
      sample_count_r <= sample_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Address stage: truncate the phase to the table address.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= ph_cur[PB-1 -: AB];
      s1_pad_r  <= !chirp_now;
      s1_last_r <= last_now;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sine and cosine (quarter turn ahead) lookup; zero the
  // samples during padding.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      if (s1_pad_r) begin
        out_i_r <= '0;
        out_q_r <= '0;
      end else begin
        out_i_r <= lcsg_pkg::sine_at(AB'(s1_addr_r + AB'(lcsg_pkg::QTR)));
        out_q_r <= lcsg_pkg::sine_at(s1_addr_r);
      end
      out_pad_r  <= s1_pad_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_i_sample = out_i_r;
  assign out_q_sample = out_q_r;
  assign out_in_pad   = out_pad_r;
  assign out_last     = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LCSG_ASSERT_SAME(a_pad_zero, out_valid_r && out_pad_r, out_i_r == '0 && out_q_r == '0, "padding sample not zero")
  `LCSG_ASSERT_SAME(a_stall_full, in_stall, s1_valid_r && out_valid_r && out_stall, "input stalled with room in the pipeline")
  `LCSG_ASSERT_NEXT(a_last_rewind, in_accept && last_now, sample_count_r == '0 && phase_acc_r == '0, "frame did not rewind after its last sample")

endmodule

`default_nettype wire
